// ===== hdl/bcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types and codes for the Bezier curve sampler.
// ----------------------------------------------------------------------------
package bcs_pkg;

	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_EVAL  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam int TW = 17;                 // t as 0.16 plus one bit for t = 1
	localparam int DIV_STEPS = TW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOAD,
		ST_LERP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic          load;   // copy control point into work register
		logic          step;   // one de Casteljau level
		logic [TW-1:0] t;
	} cell_ctl_t;

endpackage

// ===== hdl/bcs_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_ifs
// Request and result channels of the Bezier curve sampler.
// ----------------------------------------------------------------------------
interface bcs_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [9:0] point_x;
	logic [9:0] point_y;
	modport source (output valid, action, point_x, point_y, input ready);
	modport sink (input valid, action, point_x, point_y, output ready);
endinterface

interface bcs_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] curve_x;
	logic [15:0] curve_y;
	logic [5:0]  sample_index;
	logic        last_sample;
	logic        points_dropped;
	modport source (output valid, curve_x, curve_y, sample_index, last_sample,
		points_dropped, input ready);
	modport sink (input valid, curve_x, curve_y, sample_index, last_sample,
		points_dropped, output ready);
endinterface

// ===== hdl/bcs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_cell
// One control point slot and its de Casteljau work register pair.
// ----------------------------------------------------------------------------
module bcs_cell #(
	parameter int WW = 16,
	parameter int FRAC_BITS = 6
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [9:0]          px,
	input  logic [9:0]          py,
	input  bcs_pkg::cell_ctl_t  ctl,
	input  logic [WW-1:0]       nb_x,
	input  logic [WW-1:0]       nb_y,
	output logic [WW-1:0]       wx,
	output logic [WW-1:0]       wy
);
	import bcs_pkg::*;

	logic [9:0]    ctrl_x_q, ctrl_y_q;
	logic [WW-1:0] wx_q, wy_q;

	// a + round((b - a) * t / 2^16); equals the two-product form exactly
	function automatic logic [WW-1:0] lerp(input logic [WW-1:0] a,
		input logic [WW-1:0] b, input logic [TW-1:0] t);
		logic signed [WW:0]    d;
		logic signed [WW+18:0] p;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		p = d * $signed({1'b0, t}) + (WW+19)'(32768);
		return a + WW'(p >>> 16);
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ctrl_x_q <= px;
			ctrl_y_q <= py;
		end
		if (ctl.load) begin
			wx_q <= WW'(ctrl_x_q) << FRAC_BITS;
			wy_q <= WW'(ctrl_y_q) << FRAC_BITS;
		end else if (ctl.step) begin
			wx_q <= lerp(wx_q, nb_x, ctl.t);
			wy_q <= lerp(wy_q, nb_y, ctl.t);
		end
	end

	assign wx = wx_q;
	assign wy = wy_q;

endmodule

// ===== hdl/bezier_curve_sampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_curve_sampler
// Stores control points and samples their Bezier curve by de Casteljau.
// ----------------------------------------------------------------------------
// Takes one request at a time. Evaluate first runs a bit-serial divider
// that finds the step of t, then each of the segments+1 samples passes
// through a load, n-1 interpolation levels across the row of point cells
// for n stored points, and a result state that holds until ready.
// Results are 10.FRAC_BITS fixed point.
module bezier_curve_sampler #(
	parameter int MAX_POINTS = 16,
	parameter int FRAC_BITS = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [5:0] cfg_wr_data,
	bcs_req_if.sink    request,
	bcs_res_if.source  result
);
	import bcs_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int IW = $clog2(MAX_POINTS);
	localparam int WW = 10 + FRAC_BITS;

	state_t        state_q, state_d;
	logic [5:0]    seg_cfg_q, seg_q, k_q;
	logic [CW-1:0] cnt_q, lvl_q;
	logic          ovf_q;
	logic [4:0]    div_cnt_q;
	logic [TW-1:0] dq_q, t_q;
	logic [5:0]    rem_q, r_q;
	logic          acc_req, full, add_ok;
	logic [6:0]    rem_sh, rs;
	logic          ge, wrap;
	cell_ctl_t     ctl;
	logic [WW-1:0] wx [MAX_POINTS];
	logic [WW-1:0] wy [MAX_POINTS];

	assign acc_req = request.valid && request.ready;
	assign full    = (cnt_q == CW'(MAX_POINTS));
	assign add_ok  = acc_req && request.action == ACT_ADD && !full;

	assign rem_sh = {rem_q, dq_q[TW-1]};
	assign ge     = rem_sh >= {1'b0, seg_q};
	assign rs     = {1'b0, r_q} + {1'b0, rem_q};
	assign wrap   = rs >= {1'b0, seg_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc_req && request.action == ACT_EVAL) state_d = ST_DIV;
			ST_DIV:  if (div_cnt_q == 5'(DIV_STEPS - 1)) state_d = ST_LOAD;
			ST_LOAD: state_d = (cnt_q <= CW'(1)) ? ST_EMIT : ST_LERP;
			ST_LERP: if (lvl_q == cnt_q - CW'(1)) state_d = ST_EMIT;
			ST_EMIT: begin
				if (result.ready) state_d = (k_q == seg_q) ? ST_IDLE : ST_LOAD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		request.ready = (state_q == ST_IDLE);
		result.valid  = (state_q == ST_EMIT);
		ctl.load      = (state_q == ST_LOAD);
		ctl.step      = (state_q == ST_LERP);
		ctl.t         = t_q;
	end

	assign result.curve_x        = (cnt_q == '0) ? 16'd0 : 16'(wx[0]);
	assign result.curve_y        = (cnt_q == '0) ? 16'd0 : 16'(wy[0]);
	assign result.sample_index   = k_q;
	assign result.last_sample    = (k_q == seg_q);
	assign result.points_dropped = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			seg_cfg_q <= 6'd20;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) seg_cfg_q <= cfg_wr_data;
			if (acc_req) begin
				unique case (request.action)
					ACT_ADD: begin
						if (full) ovf_q <= 1'b1;
						else cnt_q <= cnt_q + CW'(1);
					end
					ACT_CLEAR: begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// t sequencing: t_k = round(k * 2^16 / seg) kept as quotient + remainder
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				seg_q     <= (seg_cfg_q == 6'd0) ? 6'd1 : seg_cfg_q;
				div_cnt_q <= '0;
				dq_q      <= TW'(1) << (TW - 1);
				rem_q     <= '0;
			end
			ST_DIV: begin
				div_cnt_q <= div_cnt_q + 5'd1;
				rem_q     <= ge ? 6'(rem_sh - {1'b0, seg_q}) : rem_sh[5:0];
				dq_q      <= {dq_q[TW-2:0], ge};
				t_q       <= '0;
				r_q       <= seg_q >> 1;
				k_q       <= '0;
			end
			ST_LOAD: lvl_q <= CW'(1);
			ST_LERP: lvl_q <= lvl_q + CW'(1);
			ST_EMIT: begin
				if (result.ready) begin
					k_q <= k_q + 6'd1;
					t_q <= t_q + dq_q + TW'(wrap);
					r_q <= wrap ? 6'(rs - {1'b0, seg_q}) : rs[5:0];
				end
			end
			default: ;
		endcase
	end

	for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
		logic [WW-1:0] nbx, nby;
		if (j == MAX_POINTS - 1) begin : g_end
			assign nbx = wx[j];
			assign nby = wy[j];
		end else begin : g_mid
			assign nbx = wx[j+1];
			assign nby = wy[j+1];
		end
		bcs_cell #(.WW(WW), .FRAC_BITS(FRAC_BITS)) u_cell (
			.clk   (clk),
			.wr_en (add_ok && cnt_q[IW-1:0] == IW'(j)),
			.px    (request.point_x),
			.py    (request.point_y),
			.ctl   (ctl),
			.nb_x  (nbx),
			.nb_y  (nby),
			.wx    (wx[j]),
			.wy    (wy[j])
		);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS)) else $error("point count past store size");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(request.ready && result.valid)) else $error("request taken mid-evaluate");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && result.last_sample |=> request.ready)
		else $error("no return to idle after last sample");
	a_t_one: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.last_sample |-> t_q == (TW'(1) << (TW - 1)))
		else $error("t not one at last sample");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the Bezier curve sampler.
// ----------------------------------------------------------------------------
// Drives add, evaluate and clear requests with random gaps on both channels,
// predicts every sample with a fixed-point de Casteljau model and checks the
// results in order. A directed table comes first, then random point sets
// evaluated under several segment counts.
module tb;
	import bcs_pkg::*;

	localparam int NPTS = 16;
	localparam int FB = 6;
	localparam logic [1:0] ACT_IGNORED = 2'd3;  // unused code, no effect

	typedef struct {
		logic [1:0] action;
		logic [9:0] px;
		logic [9:0] py;
		logic       has_exp;  // typed-in first sample
		logic [15:0] ex;
		logic [15:0] ey;
	} stim_row_t;

	typedef struct {
		logic [15:0] cx;
		logic [15:0] cy;
		logic [5:0]  idx;
		logic        last;
		logic        dropped;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [5:0] cfg_wr_data = 6'd0;
	bit   failed = 1'b0;
	bit   table_failed = 1'b0;
	bit   stim_done = 1'b0;

	bcs_req_if request ();
	bcs_res_if result ();

	bezier_curve_sampler dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.request(request), .result(result)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [9:0]  pts_x [NPTS];
	logic [9:0]  pts_y [NPTS];
	int          n_pts;
	logic        drop_seen;
	logic [5:0]  seg_reg;
	sample_t     pending_samples[$];

	function automatic logic [15:0] lerp(logic [15:0] a, logic [15:0] b, logic [16:0] t);
		logic [63:0] acc;
		acc = 64'(a) * 64'(17'h10000 - t) + 64'(b) * 64'(t) + 64'd32768;
		return acc[31:16];
	endfunction

	task automatic predict_request(logic [1:0] act, logic [9:0] px, logic [9:0] py);
		int seg;
		logic [16:0] t;
		logic [15:0] wx [NPTS];
		logic [15:0] wy [NPTS];
		sample_t s;
		case (act)
			ACT_ADD: begin
				if (n_pts < NPTS) begin
					pts_x[n_pts] = px;
					pts_y[n_pts] = py;
					n_pts++;
				end else drop_seen = 1'b1;
			end
			ACT_CLEAR: begin
				n_pts = 0;
				drop_seen = 1'b0;
			end
			ACT_EVAL: begin
				seg = (seg_reg == 6'd0) ? 1 : int'(seg_reg);
				for (int k = 0; k <= seg; k++) begin
					t = 17'((k * 65536 + seg / 2) / seg);
					s.cx = '0;
					s.cy = '0;
					if (n_pts > 0) begin
						for (int j = 0; j < n_pts; j++) begin
							wx[j] = 16'(pts_x[j]) << FB;
							wy[j] = 16'(pts_y[j]) << FB;
						end
						for (int i = 1; i < n_pts; i++)
							for (int j = 0; j + i < n_pts; j++) begin
								wx[j] = lerp(wx[j], wx[j + 1], t);
								wy[j] = lerp(wy[j], wy[j + 1], t);
							end
						s.cx = wx[0];
						s.cy = wy[0];
					end
					s.idx = 6'(k);
					s.last = (k == seg);
					s.dropped = drop_seen;
					pending_samples = {pending_samples, s};
				end
			end
			default: ;
		endcase
	endtask

	task automatic idle_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// valid stays up after a request so the next one can follow without a gap
	task automatic send_request(logic [1:0] act, logic [9:0] px, logic [9:0] py);
		int gap;
		gap = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 13)) : 0;
		if (gap > 0) begin
			request.valid <= 1'b0;
			idle_cycles(gap);
		end
		request.valid <= 1'b1;
		request.action <= act;
		request.point_x <= px;
		request.point_y <= py;
		do @(posedge clk); while (!request.ready);
		predict_request(act, px, py);
	endtask

	task automatic wait_drained();
		request.valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		idle_cycles(30);
	endtask

	task automatic write_segments(logic [5:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		seg_reg = v;
	endtask

	// result side: random stall, check against oldest expectation
	always @(posedge clk) begin
		sample_t e;
		if (arst_n && result.valid && result.ready) begin
			if (pending_samples.size() == 0) begin
				$error("unexpected result x=%0d y=%0d", result.curve_x, result.curve_y);
				failed = 1'b1;
			end else begin
				e = pending_samples.pop_front();
				if (result.curve_x !== e.cx) begin
					$error("curve_x exp %0d got %0d", e.cx, result.curve_x); failed = 1'b1;
				end
				if (result.curve_y !== e.cy) begin
					$error("curve_y exp %0d got %0d", e.cy, result.curve_y); failed = 1'b1;
				end
				if (result.sample_index !== e.idx) begin
					$error("sample_index exp %0d got %0d", e.idx, result.sample_index);
					failed = 1'b1;
				end
				if (result.last_sample !== e.last) begin
					$error("last_sample exp %0d got %0d", e.last, result.last_sample);
					failed = 1'b1;
				end
				if (result.points_dropped !== e.dropped) begin
					$error("points_dropped exp %0d got %0d", e.dropped,
						result.points_dropped);
					failed = 1'b1;
				end
			end
		end
	end

	int stall_left = 0;
	bit no_stall_phase = 1'b0;
	always @(posedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (no_stall_phase) begin
			result.ready <= 1'b1;
		end else if (result.valid && result.ready || stall_left == 0 && !result.ready) begin
			// new draw per result
			if (result.valid && result.ready) stall_left = $urandom_range(0, 13);
			result.ready <= (stall_left == 0);
		end else if (stall_left > 0) begin
			stall_left--;
			result.ready <= (stall_left == 0);
		end
	end

	stim_row_t dir_rows[$];

	function automatic stim_row_t row(logic [1:0] a, logic [9:0] x, logic [9:0] y,
		logic h = 1'b0, logic [15:0] ex = '0, logic [15:0] ey = '0);
		stim_row_t r;
		r.action = a; r.px = x; r.py = y; r.has_exp = h; r.ex = ex; r.ey = ey;
		return r;
	endfunction

	initial begin
		int npt;
		int first_pending;
		request.valid = 1'b0;
		request.action = ACT_ADD;
		request.point_x = '0;
		request.point_y = '0;
		n_pts = 0;
		drop_seen = 1'b0;
		seg_reg = 6'd20;

		// empty store gives origin; lone point gives itself; extremes
		dir_rows = {dir_rows, row(ACT_EVAL, '0, '0, 1'b1, 16'd0, 16'd0)};
		dir_rows = {dir_rows, row(ACT_ADD, 10'd1023, 10'd0)};
		dir_rows = {dir_rows, row(ACT_EVAL, '0, '0, 1'b1, 16'hffc0, 16'd0)};
		dir_rows = {dir_rows, row(ACT_IGNORED, 10'd5, 10'd5)};
		dir_rows = {dir_rows, row(ACT_ADD, 10'd0, 10'd1023)};
		dir_rows = {dir_rows, row(ACT_EVAL, '0, '0, 1'b1, 16'hffc0, 16'd0)};
		dir_rows = {dir_rows, row(ACT_CLEAR, 10'd1023, 10'd1023)};
		dir_rows = {dir_rows, row(ACT_ADD, 10'h2aa, 10'h155)};
		dir_rows = {dir_rows, row(ACT_ADD, 10'h155, 10'h2aa)};
		dir_rows = {dir_rows, row(ACT_ADD, 10'd1023, 10'd1023)};
		dir_rows = {dir_rows, row(ACT_EVAL, '0, '0)};

		arst_n = 1'b0;
		idle_cycles(2);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			first_pending = pending_samples.size();
			send_request(dir_rows[i].action, dir_rows[i].px, dir_rows[i].py);
			if (dir_rows[i].has_exp && pending_samples.size() > first_pending &&
				(pending_samples[first_pending].cx !== dir_rows[i].ex ||
				 pending_samples[first_pending].cy !== dir_rows[i].ey)) begin
				$error("predictor first sample exp %0d,%0d", dir_rows[i].ex, dir_rows[i].ey);
				table_failed = 1'b1;
			end
		end

		// full store and overflow, segments zero and 63
		write_segments(6'd0);
		for (int i = 0; i < NPTS + 2; i++)
			send_request(ACT_ADD, 10'($urandom), 10'($urandom));
		send_request(ACT_EVAL, '0, '0);
		write_segments(6'd63);
		send_request(ACT_EVAL, '0, '0);
		send_request(ACT_CLEAR, '0, '0);
		write_segments(6'd1);

		// random point sets with random contents
		for (int r = 0; r < 34; r++) begin
			if (r % 5 == 0) write_segments(6'($urandom_range(0, 63) % 12 + (r == 25 ? 52 : 0)));
			no_stall_phase = (r % 7 == 3);
			send_request(ACT_CLEAR, 10'($urandom), 10'($urandom));
			npt = ($urandom_range(0, 9) == 0) ? $urandom_range(NPTS, NPTS + 2)
				: $urandom_range(0, 5);
			for (int i = 0; i < npt; i++)
				send_request($urandom_range(0, 15) == 0 ? ACT_IGNORED : ACT_ADD,
					10'($urandom), 10'($urandom));
			send_request(ACT_EVAL, 10'($urandom), 10'($urandom));
			if (r == 10) wait_drained();
		end
		no_stall_phase = 1'b0;
		write_segments(6'd20);
		wait_drained();
		stim_done = 1'b1;
	end

	always @(posedge clk) begin
		if (stim_done) begin
			if (!failed && !table_failed) begin
				$display("bezier_curve_sampler test passed");
			end else begin
				$display("bezier_curve_sampler test failed");
			end
			$finish;
		end
	end

	initial begin
		#20_000_000;
		$display("bezier_curve_sampler test failed");
		$finish;
	end

endmodule
